/* rtl/core/rpf_pkg.sv */
// Shared constants and types for the repeating period finder.
package rpf_pkg;

    localparam int MaxLen = 1024;
    localparam int AddrW  = $clog2(MaxLen);
    localparam int CntW   = $clog2(MaxLen + 1);
    localparam int SampW  = 16;
    localparam int PreW   = SampW + CntW;
    localparam int SumW   = 48;
    localparam int QDepth = 2;

    typedef struct packed {
        logic [CntW-1:0] n;
    } rpf_job_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_PSETUP,
        ST_NORM,
        ST_KSETUP,
        ST_SCAN,
        ST_NEXT,
        ST_PREFIX,
        ST_MEAN,
        ST_DIV,
        ST_DONE
    } rpf_state_t;

endpackage

/* rtl/core/repeating_period_finder_top.sv */
// Top level of the repeating period finder.
//  channel | ports                         | direction
//  input   | s_sample s_last s_valid/ready | in
//  result  | m_best_period m_found m_valid | out
// Loading takes in items through s_valid/s_ready; scoring walks the union of both peak
// windows through the spectrum memory read port, one element per cycle, plus
// a serial divide per counted peak and two per period.
// s_ready drops from the last item until the back part takes its job; reset clears
// counts and the job queue.
module repeating_period_finder_top (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic signed [15:0] s_sample,
    input  logic               s_last,
    input  logic               s_valid,
    output logic               s_ready,
    output logic [7:0]         m_best_period,
    output logic               m_found,
    output logic               m_valid,
    input  logic               m_ready
);
    import rpf_pkg::*;

    logic job_valid, job_ready;
    rpf_job_t job;
    logic [AddrW-1:0] spec_addr;
    logic signed [15:0] spec_data;
    logic [CntW-1:0] pre_addr;
    logic signed [PreW-1:0] pre_data;

    rpf_front u_front (.*);
    rpf_back  u_back  (.*);

`ifndef SYNTHESIS
    a_found_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_found |-> m_best_period == '0) else $error("period without found");
    a_one_job: assert property (@(posedge aclk) disable iff (!aresetn)
        job_valid && job_ready |=> !job_ready) else $error("job taken twice");
`endif
endmodule

/* rtl/core/rpf_front.sv */
// Front part: stores samples and prefix sums, posts one job per spectrum.
module rpf_front (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic signed [15:0]         s_sample,
    input  logic                       s_last,
    input  logic                       s_valid,
    output logic                       s_ready,
    output logic                       job_valid,
    output rpf_pkg::rpf_job_t          job,
    input  logic                       job_ready,
    input  logic [rpf_pkg::AddrW-1:0]  spec_addr,
    output logic signed [15:0]         spec_data,
    input  logic [rpf_pkg::CntW-1:0]   pre_addr,
    output logic signed [rpf_pkg::PreW-1:0] pre_data
);
    import rpf_pkg::*;

    logic signed [15:0]     spec_mem [MaxLen];
    logic signed [PreW-1:0] pre_mem  [MaxLen];
    logic [CntW-1:0]        count_reg;
    logic signed [PreW-1:0] run_reg;
    logic                   busy_reg;
    rpf_job_t               q_mem [QDepth];
    logic [1:0]             wp_reg, rp_reg;
    logic                   accept, full, keep;

    assign full   = (wp_reg - rp_reg) == 2'(QDepth);
    assign s_ready = !full && !busy_reg;
    assign accept = s_valid && s_ready;
    assign keep   = accept && (count_reg < CntW'(MaxLen));
    assign job_valid = wp_reg != rp_reg;
    assign job = q_mem[rp_reg[0]];

    always_ff @(posedge aclk) begin
        if (keep) begin
            spec_mem[count_reg[AddrW-1:0]] <= s_sample;
            pre_mem[count_reg[AddrW-1:0]]  <= run_reg + PreW'(s_sample);
        end
        spec_data <= spec_mem[spec_addr];
        pre_data  <= (pre_addr == '0) ? '0 : pre_mem[AddrW'(pre_addr - 1'b1)];
        if (accept && s_last) begin
            q_mem[wp_reg[0]].n <= keep ? count_reg + 1'b1 : count_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
            run_reg   <= '0;
            wp_reg    <= '0;
            rp_reg    <= '0;
            busy_reg  <= 1'b0;
        end else begin
            if (accept) begin
                if (s_last) begin
                    count_reg <= '0;
                    run_reg   <= '0;
                    wp_reg    <= wp_reg + 1'b1;
                    busy_reg  <= 1'b1;
                end else if (keep) begin
                    count_reg <= count_reg + 1'b1;
                    run_reg   <= run_reg + PreW'(s_sample);
                end
            end
            if (job_valid && job_ready) begin
                rp_reg   <= rp_reg + 1'b1;
                busy_reg <= 1'b0;
            end
        end
    end
endmodule

/* rtl/core/rpf_back.sv */
// Back part: scores each candidate period and reports the best one.
module rpf_back (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       job_valid,
    input  rpf_pkg::rpf_job_t          job,
    output logic                       job_ready,
    output logic [rpf_pkg::AddrW-1:0]  spec_addr,
    input  logic signed [15:0]         spec_data,
    output logic [rpf_pkg::CntW-1:0]   pre_addr,
    input  logic signed [rpf_pkg::PreW-1:0] pre_data,
    output logic [7:0]                 m_best_period,
    output logic                       m_found,
    output logic                       m_valid,
    input  logic                       m_ready
);
    import rpf_pkg::*;

    localparam int DivW = SumW + 8;

    rpf_state_t state_reg, state_next;
    logic [CntW-1:0] n_reg, a_reg, p_reg, k_reg;
    logic [CntW-1:0] r_reg, big_reg, norm_reg;
    logic [CntW-1:0] slo_reg, shi_reg, blo_reg, bhi_reg, i_reg, ia_reg, end_reg;
    logic [CntW-1:0] slo_c, shi_c, blo_c, bhi_c;
    logic [CntW-1:0] np_reg, bp_reg;
    logic signed [15:0] nv_reg, bv_reg;
    logic nhave_reg, bhave_reg, dv_reg;
    logic [1:0] ph_reg;
    logic signed [PreW-1:0] ph_lo_reg;
    logic signed [SumW-1:0] sum_reg, best_reg;
    logic [7:0]  bidx_reg;
    logic        found_reg, ovalid_reg;
    logic [7:0]  oper_reg;
    logic        ofound_reg;
    logic        p_fits;
    // shared serial divider: unsigned magnitude restoring division
    logic [DivW-1:0] dq_reg;
    logic [CntW:0]   drem_reg;
    logic [CntW-1:0] dden_reg;
    logic [6:0]      dcnt_reg;
    logic            dneg_reg, dmean_reg;
    logic signed [SumW-1:0] score;
    logic [CntW:0] dtry;

    assign job_ready = (state_reg == ST_DONE);
    assign m_valid = ovalid_reg;
    assign m_best_period = oper_reg;
    assign m_found = ofound_reg;
    assign spec_addr = AddrW'(i_reg);
    assign pre_addr = (ph_reg == 2'd0) ? blo_reg : bhi_reg;
    assign dtry = {drem_reg[CntW-1:0], dq_reg[DivW-1]};
    assign score = dneg_reg ? -SumW'(dq_reg) : SumW'(dq_reg);
    assign p_fits = ((CntW+2)'(p_reg) + (CntW+2)'(1)) * (CntW+2)'(3) <= (CntW+2)'(a_reg);
    assign slo_c = (k_reg >= r_reg) ? k_reg - r_reg : '0;
    assign shi_c = (k_reg + r_reg + 1'b1 < n_reg) ? k_reg + r_reg + 1'b1 : n_reg;
    assign blo_c = (k_reg >= big_reg) ? k_reg - big_reg : '0;
    assign bhi_c = (k_reg + big_reg + 1'b1 < n_reg) ? k_reg + big_reg + 1'b1 : n_reg;

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:   if (job_valid && !ovalid_reg) state_next = ST_PSETUP;
            ST_PSETUP: state_next = p_fits ? ST_NORM : ST_DONE;
            ST_NORM:   if (dcnt_reg == '0) state_next = ST_KSETUP;
            ST_KSETUP: state_next = (k_reg < n_reg) ? ST_SCAN : ST_DIV;
            ST_SCAN:   if (i_reg == end_reg && dv_reg) state_next = ST_NEXT;
            ST_NEXT:   state_next = (np_reg == bp_reg) ? ST_PREFIX : ST_KSETUP;
            ST_PREFIX: if (ph_reg == 2'd2) state_next = ST_MEAN;
            ST_MEAN:   if (dcnt_reg == '0) state_next = ST_KSETUP;
            ST_DIV:    if (dcnt_reg == '0) state_next = ST_PSETUP;
            ST_DONE:   state_next = ST_IDLE;
            default:   state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= ST_IDLE;
            ovalid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (state_reg == ST_DONE) ovalid_reg <= 1'b1;
            else if (m_ready) ovalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        case (state_reg)
            ST_IDLE: begin
                n_reg <= job.n;
                a_reg <= CntW'(({2'b0, job.n} * 3) >> 2);
                p_reg <= CntW'(1);
                found_reg <= 1'b0;
                bidx_reg <= '0;
                best_reg <= {1'b1, {(SumW-1){1'b0}}};
                dv_reg <= 1'b0;
            end
            ST_PSETUP: begin
                r_reg   <= (p_reg < CntW'(20)) ? CntW'(1) :
                           CntW'((32'(p_reg) * 32'd205) >> 12);
                big_reg <= CntW'(({2'b0, p_reg} * 3) >> 2);
                k_reg   <= p_reg;
                sum_reg <= '0;
                dv_reg  <= 1'b0;
                dneg_reg <= 1'b0;
                dq_reg   <= DivW'(a_reg);
                dden_reg <= p_reg;
                drem_reg <= '0;
                dcnt_reg <= 7'(DivW);
            end
            ST_KSETUP: begin
                slo_reg <= slo_c;
                shi_reg <= shi_c;
                blo_reg <= blo_c;
                bhi_reg <= bhi_c;
                i_reg   <= (slo_c < blo_c) ? slo_c : blo_c;
                end_reg <= (shi_c > bhi_c) ? shi_c : bhi_c;
                nhave_reg <= 1'b0;
                bhave_reg <= 1'b0;
                dv_reg <= 1'b0;
                ph_reg <= '0;
                if (k_reg >= n_reg) begin
                    dneg_reg <= sum_reg < 0;
                    dq_reg   <= DivW'(sum_reg < 0 ? -sum_reg : sum_reg) << 8;
                    drem_reg <= '0;
                    dcnt_reg <= 7'(DivW);
                    dmean_reg <= 1'b0;
                    dden_reg <= norm_reg;
                end
            end
            ST_SCAN: begin
                ia_reg <= i_reg;
                dv_reg <= 1'b1;
                if (i_reg != end_reg) i_reg <= i_reg + 1'b1;
                if (dv_reg) begin
                    if (ia_reg >= blo_reg && ia_reg < bhi_reg &&
                        (!bhave_reg || spec_data > bv_reg)) begin
                        bv_reg <= spec_data; bp_reg <= ia_reg; bhave_reg <= 1'b1;
                    end
                    if (ia_reg >= slo_reg && ia_reg < shi_reg &&
                        (!nhave_reg || spec_data > nv_reg)) begin
                        nv_reg <= spec_data; np_reg <= ia_reg; nhave_reg <= 1'b1;
                    end
                end
            end
            ST_NEXT: begin
                k_reg <= k_reg + p_reg;
                ph_reg <= '0;
            end
            ST_PREFIX: begin
                ph_reg <= ph_reg + 1'b1;
                if (ph_reg == 2'd1) ph_lo_reg <= pre_data;
                if (ph_reg == 2'd2) begin
                    dneg_reg <= (pre_data - ph_lo_reg) < 0;
                    dq_reg <= DivW'((pre_data - ph_lo_reg) < 0 ?
                        ph_lo_reg - pre_data : pre_data - ph_lo_reg);
                    dden_reg <= bhi_reg - blo_reg;
                    drem_reg <= '0;
                    dcnt_reg <= 7'(DivW);
                    dmean_reg <= 1'b1;
                end
            end
            ST_NORM, ST_MEAN, ST_DIV: begin
                if (dcnt_reg != '0) begin
                    dcnt_reg <= dcnt_reg - 1'b1;
                    if (dtry >= {1'b0, dden_reg}) begin
                        drem_reg <= dtry - {1'b0, dden_reg};
                        dq_reg <= {dq_reg[DivW-2:0], 1'b1};
                    end else begin
                        drem_reg <= dtry;
                        dq_reg <= {dq_reg[DivW-2:0], 1'b0};
                    end
                end else if (state_reg == ST_NORM) begin
                    norm_reg <= CntW'(dq_reg);
                end else if (dmean_reg) begin
                    // floor: negative with remainder rounds down
                    sum_reg <= sum_reg + SumW'(nv_reg) - (dneg_reg ?
                        -(SumW'(dq_reg) + SumW'(drem_reg != '0)) : SumW'(dq_reg));
                end else begin
                    if (!found_reg || score > best_reg) begin
                        best_reg <= score;
                        bidx_reg <= p_reg[7:0];
                        found_reg <= 1'b1;
                    end
                    p_reg <= p_reg + 1'b1;
                end
            end
            ST_DONE: begin
                oper_reg <= found_reg ? bidx_reg : '0;
                ofound_reg <= found_reg;
            end
            default: ;
        endcase
    end
endmodule
